// ===== src/assert_macros.svh =====
// Assertion macros shared by the credential lock RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks that a condition holds at every clock edge outside reset.
`define CEL_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that a condition implies another one in the same cycle.
`define CEL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that a condition implies another one in the next cycle.
`define CEL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define CEL_ASSERT_ALWAYS(lbl, expr, msg)
`define CEL_ASSERT_SAME(lbl, ante, cons, msg)
`define CEL_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/cel_pkg.sv =====
// Shared constants and types of the credential lock.
package cel_pkg;

  localparam int MAX_LEN = 20;
  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int MINL_W  = 5;
  localparam int CMP_W   = (LEN_W > MINL_W) ? LEN_W : MINL_W;
  localparam int TRIES_W = 4;
  localparam int SECS_W  = 4;
  localparam int BYTE_W  = 8;

  // Command codes of the input word.
  localparam logic [1:0] CMD_KEY    = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_ENROLL = 2'd2;

  // Special characters.
  localparam logic [7:0] KEY_CR    = 8'h0D;
  localparam logic [7:0] KEY_SI    = 8'h0F;
  localparam logic [7:0] KEY_BKSP  = 8'h08;

  // Event codes of the result word.
  localparam logic [3:0] EV_NONE     = 4'd0;
  localparam logic [3:0] EV_ECHO     = 4'd1;
  localparam logic [3:0] EV_ERASE    = 4'd2;
  localparam logic [3:0] EV_DONE     = 4'd3;
  localparam logic [3:0] EV_SHORT    = 4'd4;
  localparam logic [3:0] EV_OK       = 4'd5;
  localparam logic [3:0] EV_FAIL     = 4'd6;
  localparam logic [3:0] EV_LOCK     = 4'd7;
  localparam logic [3:0] EV_TICK     = 4'd8;
  localparam logic [3:0] EV_UNLOCK   = 4'd9;
  localparam logic [3:0] EV_ENROLLED = 4'd10;

  // Configuration register indexes.
  localparam logic [1:0] REG_TRIES_LIMIT = 2'd0;
  localparam logic [1:0] REG_MIN_LENGTH  = 2'd1;
  localparam logic [1:0] REG_LOCK_SECS   = 2'd2;

  // Request from the control logic to the byte sweep unit.
  typedef struct packed {
    logic             start;
    logic             copy;
    logic [LEN_W-1:0] len;
  } sweep_req_t;

  // Completion status of the byte sweep unit.
  typedef struct packed {
    logic done;
    logic match;
  } sweep_stat_t;

endpackage

// ===== src/cel_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 20
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/cel_sweep.sv =====
// Byte sweep unit: compares or copies a line one byte per cycle.
`include "assert_macros.svh"

module cel_sweep (
  input  logic                            clk,
  input  logic                            rst,
  input  cel_pkg::sweep_req_t             req,
  input  logic [cel_pkg::BYTE_W-1:0]      entry_data,
  input  logic [cel_pkg::BYTE_W-1:0]      stored_data,
  output logic [cel_pkg::IDX_W-1:0]       rd_addr,
  output logic                            st_we,
  output logic [cel_pkg::IDX_W-1:0]       st_addr,
  output logic [cel_pkg::BYTE_W-1:0]      st_data,
  output cel_pkg::sweep_stat_t            stat
);

  logic                        busy;
  logic                        op_copy;
  logic [cel_pkg::LEN_W-1:0]   cnt;
  logic [cel_pkg::LEN_W-1:0]   len_r;
  logic                        pend;
  logic                        pend_last;
  logic [cel_pkg::IDX_W-1:0]   pend_addr;
  logic                        same;
  logic                        eq;
  logic                        last_issue;

  assign rd_addr    = cnt[cel_pkg::IDX_W-1:0];
  assign last_issue = (cnt + cel_pkg::LEN_W'(1)) == len_r;
  assign eq         = entry_data == stored_data;

  // Read data arrives in the cycle after its address; it is written back or compared then.
  assign st_we   = pend && op_copy;
  assign st_addr = pend_addr;
  assign st_data = entry_data;

  assign stat.done  = pend && pend_last;
  assign stat.match = op_copy || (same && eq);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pend <= 1'b0;
    end else begin
      pend <= busy;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && last_issue) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt     <= '0;
      len_r   <= req.len;
      op_copy <= req.copy;
      same    <= 1'b1;
    end else begin
      if (busy) begin
        cnt <= cnt + cel_pkg::LEN_W'(1);
      end
      if (pend && !eq) begin
        same <= 1'b0;
      end
    end
    pend_addr <= cnt[cel_pkg::IDX_W-1:0];
    pend_last <= last_issue;
  end

  `CEL_ASSERT_SAME(a_start_idle, req.start, !busy && !pend, "sweep started while busy")
  `CEL_ASSERT_NEXT(a_busy_feeds, busy, pend, "issued read produced no data cycle")
  `CEL_ASSERT_SAME(a_done_single, stat.done, !busy, "sweep done while still issuing")

endmodule

// ===== src/credential_entry_lock_top.sv =====
// Top level of the credential lock: line editing, enrollment, sign-in and lockout.
//
// Input words arrive on s_tvalid/s_tready: s_tuser carries the command (key byte,
// one-second tick or begin enrollment) and s_tdata the key byte. Every accepted
// input word gives exactly one result word on m_tvalid/m_tready: m_tuser holds
// the event code, m_tdata the echoed byte, the tries left and the lockout
// seconds left. Configuration is written through cfg_we, cfg_index and cfg_data;
// the user must do so only while the block is idle, as the block does not enforce it.
// There is no read-back. Most words finish in the cycle they are accepted, and
// their result is valid the next cycle. An Enter that checks or stores a line
// sweeps the line through one shared byte unit over the line RAMs, one byte per
// cycle, and its result is registered when the unit reports the last byte done.
// The block accepts one word at a time: s_tready is low during a sweep, and low
// while a result waits in the output register and the receiver holds m_tready low.
// Synchronous reset returns to sign-in username entry with empty lines, the
// configuration registers at their defaults and the tries left at the tries limit.
// Stored credentials are held in RAMs that reset does not clear.
`include "assert_macros.svh"

module credential_entry_lock_top (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] key_byte
  input  logic [1:0]  s_tuser,   // [1:0] cmd
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] echo_byte, [11:8] tries_left, [15:12] seconds_left
  output logic [3:0]  m_tuser,   // [3:0] event_res
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  // Operating modes.
  localparam logic [2:0] M_USER     = 3'd0;
  localparam logic [2:0] M_PASS     = 3'd1;
  localparam logic [2:0] M_ENR_USER = 3'd2;
  localparam logic [2:0] M_ENR_PASS = 3'd3;
  localparam logic [2:0] M_ERR_USER = 3'd4;
  localparam logic [2:0] M_ERR_PASS = 3'd5;
  localparam logic [2:0] M_LOCK     = 3'd6;

  // Sequencer states.
  localparam logic S_IDLE  = 1'b0;
  localparam logic S_SWEEP = 1'b1;

  localparam int LW = cel_pkg::LEN_W;
  localparam int IW = cel_pkg::IDX_W;
  localparam int TW = cel_pkg::TRIES_W;
  localparam int SW = cel_pkg::SECS_W;
  localparam int BW = cel_pkg::BYTE_W;

  // Configuration registers.
  logic [TW-1:0]              tries_limit;
  logic [cel_pkg::MINL_W-1:0] min_length;
  logic [SW-1:0]              lock_secs;

  // Control state and its next values.
  logic          state, state_next;
  logic [2:0]    mode, mode_next;
  logic [LW-1:0] entry_len, entry_len_next;
  logic [LW-1:0] user_len, user_len_next;
  logic [LW-1:0] pass_len, pass_len_next;
  logic          user_match, user_match_next;
  logic [TW-1:0] tries, tries_next;
  logic [SW-1:0] lock_cnt, lock_cnt_next;

  // Result register.
  logic          m_valid;
  logic [3:0]    out_ev;
  logic [BW-1:0] out_echo;
  logic [TW-1:0] out_tries;
  logic [SW-1:0] out_secs;

  // Step signals.
  logic          accept;
  logic          enter;
  logic          back;
  logic [BW-1:0] key;
  logic          emit;
  logic [3:0]    ev;
  logic [BW-1:0] echo;
  logic          fin;
  logic          fin_match;
  logic [TW-1:0] tries_dec;
  logic          is_signin;
  logic          len_eq;
  logic          too_short;
  logic          sel_pass;

  // RAM and sweep signals.
  logic                 ent_we;
  logic [BW-1:0]        ent_rd;
  logic [BW-1:0]        user_rd;
  logic [BW-1:0]        pass_rd;
  logic [BW-1:0]        stored_rd;
  logic [IW-1:0]        rd_addr;
  logic                 sw_we;
  logic [IW-1:0]        sw_addr;
  logic [BW-1:0]        sw_data;
  cel_pkg::sweep_req_t  req;
  cel_pkg::sweep_stat_t stat;

  assign key    = s_tdata;
  assign enter  = (key == cel_pkg::KEY_CR) || (key == cel_pkg::KEY_SI);
  assign back   = key == cel_pkg::KEY_BKSP;
  assign accept = s_tvalid && s_tready;

  assign s_tready = (state == S_IDLE) && (!m_valid || m_tready);
  assign m_tvalid = m_valid;
  assign m_tuser  = out_ev;
  assign m_tdata  = {out_secs, out_tries, out_echo};

  assign is_signin = (mode == M_USER) || (mode == M_PASS);
  assign sel_pass  = (mode == M_PASS) || (mode == M_ENR_PASS);
  assign len_eq    = entry_len == ((mode == M_USER) ? user_len : pass_len);
  assign too_short = cel_pkg::CMP_W'(entry_len) < cel_pkg::CMP_W'(min_length);
  assign tries_dec = (tries != '0) ? (tries - TW'(1)) : '0;
  assign stored_rd = sel_pass ? pass_rd : user_rd;

  always_comb begin
    state_next      = state;
    mode_next       = mode;
    entry_len_next  = entry_len;
    user_len_next   = user_len;
    pass_len_next   = pass_len;
    user_match_next = user_match;
    tries_next      = tries;
    lock_cnt_next   = lock_cnt;
    ev              = cel_pkg::EV_NONE;
    echo            = '0;
    emit            = 1'b0;
    fin             = 1'b0;
    fin_match       = 1'b0;
    ent_we          = 1'b0;
    req.start       = 1'b0;
    req.copy        = !is_signin;
    req.len         = entry_len;

    if (state == S_IDLE) begin
      if (accept) begin
        emit = 1'b1;
        case (s_tuser)
          cel_pkg::CMD_TICK: begin
            if (mode == M_LOCK) begin
              if (lock_cnt <= SW'(1)) begin
                lock_cnt_next = '0;
                tries_next    = tries_limit;
                mode_next     = M_USER;
                ev            = cel_pkg::EV_UNLOCK;
              end else begin
                lock_cnt_next = lock_cnt - SW'(1);
                ev            = cel_pkg::EV_TICK;
              end
            end
          end
          cel_pkg::CMD_ENROLL: begin
            if (mode != M_LOCK) begin
              mode_next      = M_ENR_USER;
              entry_len_next = '0;
            end
          end
          cel_pkg::CMD_KEY: begin
            if ((mode == M_ERR_USER) || (mode == M_ERR_PASS)) begin
              // Only Enter clears the error and restarts the same line.
              if (enter) begin
                mode_next      = (mode == M_ERR_USER) ? M_ENR_USER : M_ENR_PASS;
                entry_len_next = '0;
              end
            end else if (mode != M_LOCK) begin
              if (entry_len == '0) begin
                if (!enter && !back) begin
                  ent_we         = 1'b1;
                  entry_len_next = LW'(1);
                  ev             = cel_pkg::EV_ECHO;
                  echo           = key;
                end
              end else if (enter) begin
                if (is_signin) begin
                  // Equal lengths need the byte compare; otherwise the check fails now.
                  if (len_eq) begin
                    emit       = 1'b0;
                    req.start  = 1'b1;
                    state_next = S_SWEEP;
                  end else begin
                    emit = 1'b0;
                    fin  = 1'b1;
                  end
                end else if (too_short) begin
                  mode_next      = (mode == M_ENR_USER) ? M_ERR_USER : M_ERR_PASS;
                  entry_len_next = '0;
                  ev             = cel_pkg::EV_SHORT;
                end else begin
                  // Long enough: copy the line into the stored credential.
                  emit       = 1'b0;
                  req.start  = 1'b1;
                  state_next = S_SWEEP;
                end
              end else if (back) begin
                entry_len_next = entry_len - LW'(1);
                ev             = cel_pkg::EV_ERASE;
              end else if (entry_len < LW'(cel_pkg::MAX_LEN)) begin
                ent_we         = 1'b1;
                entry_len_next = entry_len + LW'(1);
                ev             = cel_pkg::EV_ECHO;
                echo           = key;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end else if (stat.done) begin
      fin        = 1'b1;
      fin_match  = stat.match;
      state_next = S_IDLE;
    end

    // End of a line: apply the check or store its result.
    if (fin) begin
      emit           = 1'b1;
      entry_len_next = '0;
      case (mode)
        M_USER: begin
          user_match_next = fin_match;
          mode_next       = M_PASS;
          ev              = cel_pkg::EV_DONE;
        end
        M_PASS: begin
          if (user_match && fin_match) begin
            mode_next = M_USER;
            ev        = cel_pkg::EV_OK;
          end else begin
            tries_next = tries_dec;
            if (tries_dec != '0) begin
              mode_next = M_USER;
              ev        = cel_pkg::EV_FAIL;
            end else begin
              mode_next     = M_LOCK;
              lock_cnt_next = lock_secs;
              ev            = cel_pkg::EV_LOCK;
            end
          end
        end
        M_ENR_USER: begin
          user_len_next = entry_len;
          mode_next     = M_ENR_PASS;
          ev            = cel_pkg::EV_DONE;
        end
        default: begin
          pass_len_next = entry_len;
          mode_next     = M_USER;
          ev            = cel_pkg::EV_ENROLLED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tries_limit <= TW'(3);
      min_length  <= cel_pkg::MINL_W'(6);
      lock_secs   <= SW'(6);
      state       <= S_IDLE;
      mode        <= M_USER;
      entry_len   <= '0;
      user_len    <= '0;
      pass_len    <= '0;
      user_match  <= 1'b1;
      tries       <= TW'(3);
      lock_cnt    <= '0;
      m_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cel_pkg::REG_TRIES_LIMIT: tries_limit <= cfg_data[TW-1:0];
          cel_pkg::REG_MIN_LENGTH:  min_length  <= cfg_data[cel_pkg::MINL_W-1:0];
          cel_pkg::REG_LOCK_SECS:   lock_secs   <= cfg_data[SW-1:0];
          default: begin
          end
        endcase
      end
      state      <= state_next;
      mode       <= mode_next;
      entry_len  <= entry_len_next;
      user_len   <= user_len_next;
      pass_len   <= pass_len_next;
      user_match <= user_match_next;
      tries      <= tries_next;
      lock_cnt   <= lock_cnt_next;
      if (emit) begin
        m_valid <= 1'b1;
      end else if (m_tready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ev    <= ev;
      out_echo  <= echo;
      out_tries <= tries_next;
      out_secs  <= lock_cnt_next;
    end
  end

  // Line being typed.
  cel_ram #(.WIDTH(BW), .DEPTH(cel_pkg::MAX_LEN)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (entry_len[IW-1:0]),
    .wdata (key),
    .raddr (rd_addr),
    .rdata (ent_rd)
  );

  // Enrolled username.
  cel_ram #(.WIDTH(BW), .DEPTH(cel_pkg::MAX_LEN)) u_user_ram (
    .clk   (clk),
    .we    (sw_we && !sel_pass),
    .waddr (sw_addr),
    .wdata (sw_data),
    .raddr (rd_addr),
    .rdata (user_rd)
  );

  // Enrolled password.
  cel_ram #(.WIDTH(BW), .DEPTH(cel_pkg::MAX_LEN)) u_pass_ram (
    .clk   (clk),
    .we    (sw_we && sel_pass),
    .waddr (sw_addr),
    .wdata (sw_data),
    .raddr (rd_addr),
    .rdata (pass_rd)
  );

  cel_sweep u_sweep (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .entry_data  (ent_rd),
    .stored_data (stored_rd),
    .rd_addr     (rd_addr),
    .st_we       (sw_we),
    .st_addr     (sw_addr),
    .st_data     (sw_data),
    .stat        (stat)
  );

  `CEL_ASSERT_SAME(a_sweep_blocks_input, state == S_SWEEP, !s_tready, "input taken during sweep")
  `CEL_ASSERT_SAME(a_lock_count_mode, lock_cnt != '0, mode == M_LOCK, "lockout count outside lockout")
  `CEL_ASSERT_SAME(a_done_in_sweep, stat.done, state == S_SWEEP, "sweep finished while idle")
  `CEL_ASSERT_SAME(a_result_free, fin, !m_valid || m_tready, "result overwrites a waiting word")

endmodule
